@@ rtl/frb_pkg.sv @@
// shared constants, types and helpers of the framed ring buffer
`default_nettype none
package frb_pkg;

    localparam int DEPTH     = 1024;
    localparam int MAX_CHUNK = 64;

    localparam int SIZE_W    = 7;
    localparam int SAMPLE_W  = 32;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W     = $clog2(DEPTH + 1);
    localparam int POS_W     = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
    localparam int SUM_W     = ((ADDR_W > SIZE_W) ? ADDR_W : SIZE_W) + 1;
    localparam int OCMP_W    = ((OCC_W > SIZE_W) ? OCC_W : SIZE_W) + 1;

    // output queue
    localparam int OUT_DEPTH = 4;
    localparam int OQ_AW     = $clog2(OUT_DEPTH);
    localparam int OQ_CW     = $clog2(OUT_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN    = 1'd1;

    localparam logic ST_ACCEPTED = 1'b0;
    localparam logic ST_REJECTED = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic                status;
        logic                last;
    } t_res;

    // zero acts as one, anything above the chunk limit acts as the limit
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_CHUNK)) begin
            r = SIZE_W'(MAX_CHUNK);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // base + inc modulo DEPTH, inc stays below DEPTH wherever it is used
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [SUM_W-1:0]  inc);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + inc;
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return ADDR_W'(s);
    endfunction

endpackage
`default_nettype wire

@@ rtl/frb_ram.sv @@
// single port write, single port read synchronous sample memory
`default_nettype none
module frb_ram #(
    parameter int DATA_W = 32,
    parameter int WORDS  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [WORDS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/frb_outq.sv @@
// small result queue between the sequencer and the master stream
`default_nettype none
module frb_outq (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  frb_pkg::t_res                  i_res,
    output logic      [frb_pkg::OQ_CW-1:0] o_count,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output frb_pkg::t_res                  o_res
);

    frb_pkg::t_res r_q [frb_pkg::OUT_DEPTH];
    logic [frb_pkg::OQ_AW-1:0] r_wp, r_rp;
    logic [frb_pkg::OQ_CW-1:0] r_cnt;
    logic pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_res;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == frb_pkg::OQ_AW'(frb_pkg::OUT_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == frb_pkg::OQ_AW'(frb_pkg::OUT_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + frb_pkg::OQ_CW'(i_push) - frb_pkg::OQ_CW'(pop);
        end
    end

    assign o_res   = r_q[r_rp];
    assign o_count = r_cnt;

endmodule
`default_nettype wire

@@ rtl/framed_ring_buffer_window_read_core.sv @@
// top level: command sequencer around the sample memory and the result queue
//
// Channels: slave stream takes commands, tuser[1:0] is the command (0 write
// sample, 1 read window, 2 flush, 3 ignored) and tdata the sample for writes.
// Master stream returns results: tdata is the sample, tuser[0] the status
// (0 accepted, 1 rejected), tlast marks the final result of a command.
// The cfg channel writes the frame size (index 0) and the window length
// (index 1); it is always ready and must be used only while the block is idle.
// Write samples and flushes are taken only while idle; the last sample
// of a frame and a rejected read put one status result in the queue.
// A granted read streams the window out of the memory, one read port
// access per cycle while the result queue has room; each sample is
// registered at the memory output and then in the result queue before it
// shows on the master side. The memory has a single read port, so a read
// window occupies the block until its last sample has been fetched.
// Reset clears pointers, occupancy, the partial frame and the result queue;
// memory contents are not cleared and need no clearing pass.
// A stalled receiver fills the four-entry result queue; memory reads and new
// requests then wait, nothing is dropped.
`default_nettype none
module framed_ring_buffer_window_read_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave stream: tdata = sample[31:0]; tuser = command[1:0]
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [frb_pkg::SAMPLE_W-1:0]     i_s_tdata,
    input  wire logic [frb_pkg::CMD_W-1:0]        i_s_tuser,
    // master stream: tdata = sample_out[31:0]; tuser = status[0]
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic      [frb_pkg::SAMPLE_W-1:0]     o_m_tdata,
    output logic      [0:0]                       o_m_tuser,
    output logic                                  o_m_tlast,
    // configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [frb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [frb_pkg::SIZE_W-1:0]       i_cfg_data
);

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state r_state, n_state;
    logic [frb_pkg::SIZE_W-1:0] r_frame_size, r_win_len;
    logic [frb_pkg::ADDR_W-1:0] r_wp, n_wp, r_rp, n_rp, r_rd_addr, n_rd_addr;
    logic [frb_pkg::OCC_W-1:0]  r_occ, n_occ;
    logic [frb_pkg::POS_W-1:0]  r_fp, n_fp;
    logic                       r_facc, n_facc;
    logic [frb_pkg::SIZE_W-1:0] r_rd_left, n_rd_left;
    logic                       r_rd_vld, n_rd_vld, r_rd_last, n_rd_last;

    logic [frb_pkg::SIZE_W-1:0]   fs, ws;
    logic [frb_pkg::OQ_CW-1:0]    oq_cnt;
    logic                         in_acc, issue, frame_ok, frame_end;
    logic                         ram_we;
    logic [frb_pkg::ADDR_W-1:0]   ram_waddr;
    logic [frb_pkg::SAMPLE_W-1:0] ram_rdata;
    logic                         push;
    frb_pkg::t_res                push_res, out_res;

    assign o_cfg_ready = 1'b1;
    assign fs = frb_pkg::clamp_size(r_frame_size);
    assign ws = frb_pkg::clamp_size(r_win_len);

    // no request while a read is streaming or its last word is still in flight
    assign o_s_tready = (r_state == S_IDLE) && !r_rd_vld &&
                        (oq_cnt < frb_pkg::OQ_CW'(frb_pkg::OUT_DEPTH));
    assign in_acc = i_s_tvalid && o_s_tready;
    assign issue  = (r_state == S_READ) &&
                    ((oq_cnt + frb_pkg::OQ_CW'(r_rd_vld)) <
                     frb_pkg::OQ_CW'(frb_pkg::OUT_DEPTH));

    // take the frame only if it still leaves the store short of full
    assign frame_ok  = (r_fp == '0)
                     ? ((frb_pkg::OCMP_W'(r_occ) + frb_pkg::OCMP_W'(fs)) <
                        frb_pkg::OCMP_W'(frb_pkg::DEPTH))
                     : r_facc;
    assign frame_end = (frb_pkg::SIZE_W'(r_fp) + 1'b1) >= fs;
    assign ram_waddr = frb_pkg::wrap_add(r_wp, frb_pkg::SUM_W'(r_fp));

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_occ     = r_occ;
        n_fp      = r_fp;
        n_facc    = r_facc;
        n_rd_addr = r_rd_addr;
        n_rd_left = r_rd_left;
        n_rd_vld  = issue;
        n_rd_last = r_rd_last;
        ram_we    = 1'b0;
        push      = 1'b0;
        push_res  = '0;
        if (r_rd_vld) begin
            push              = 1'b1;
            push_res.sample_out = ram_rdata;
            push_res.status   = frb_pkg::ST_ACCEPTED;
            push_res.last     = r_rd_last;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_s_tuser)
                        frb_pkg::CMD_WRITE: begin
                            ram_we = frame_ok;
                            if (frame_end) begin
                                if (frame_ok) begin
                                    n_wp  = frb_pkg::wrap_add(r_wp, frb_pkg::SUM_W'(fs));
                                    n_occ = r_occ + frb_pkg::OCC_W'(fs);
                                end
                                n_fp            = '0;
                                n_facc          = 1'b0;
                                push            = 1'b1;
                                push_res.status = frame_ok ? frb_pkg::ST_ACCEPTED
                                                           : frb_pkg::ST_REJECTED;
                                push_res.last   = 1'b1;
                            end else begin
                                n_fp   = r_fp + 1'b1;
                                n_facc = frame_ok;
                            end
                        end
                        frb_pkg::CMD_READ: begin
                            if (frb_pkg::OCMP_W'(r_occ) > frb_pkg::OCMP_W'(ws)) begin
                                n_rd_addr = r_rp;
                                n_rd_left = ws;
                                n_rp      = frb_pkg::wrap_add(r_rp, frb_pkg::SUM_W'(ws));
                                n_occ     = r_occ - frb_pkg::OCC_W'(ws);
                                n_state   = S_READ;
                            end else begin
                                push            = 1'b1;
                                push_res.status = frb_pkg::ST_REJECTED;
                                push_res.last   = 1'b1;
                            end
                        end
                        frb_pkg::CMD_FLUSH: begin
                            n_wp   = '0;
                            n_rp   = '0;
                            n_occ  = '0;
                            n_fp   = '0;
                            n_facc = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (issue) begin
                    n_rd_addr = frb_pkg::wrap_add(r_rd_addr, frb_pkg::SUM_W'(1));
                    n_rd_left = r_rd_left - 1'b1;
                    n_rd_last = (r_rd_left == frb_pkg::SIZE_W'(1));
                    if (r_rd_left == frb_pkg::SIZE_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_size  <= frb_pkg::SIZE_W'(1);
            r_win_len     <= frb_pkg::SIZE_W'(1);
            r_wp          <= '0;
            r_rp          <= '0;
            r_occ         <= '0;
            r_fp          <= '0;
            r_facc        <= 1'b0;
            r_rd_addr     <= '0;
            r_rd_left     <= '0;
            r_rd_vld      <= 1'b0;
            r_rd_last     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_occ     <= n_occ;
            r_fp      <= n_fp;
            r_facc    <= n_facc;
            r_rd_addr <= n_rd_addr;
            r_rd_left <= n_rd_left;
            r_rd_vld  <= n_rd_vld;
            r_rd_last <= n_rd_last;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    frb_pkg::REG_FRAME_SIZE: r_frame_size <= i_cfg_data;
                    frb_pkg::REG_WIN_LEN:    r_win_len    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    frb_ram #(
        .DATA_W (frb_pkg::SAMPLE_W),
        .WORDS  (frb_pkg::DEPTH),
        .ADDR_W (frb_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_s_tdata),
        .i_re    (issue),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    frb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (push_res),
        .o_count (oq_cnt),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = out_res.sample_out;
    assign o_m_tuser = out_res.status;
    assign o_m_tlast = out_res.last;

endmodule
`default_nettype wire

@@ rtl/frb_checker.sv @@
// port level checks of the framed ring buffer and their binding
`default_nettype none
module frb_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_s_tvalid,
    input wire logic                         o_s_tready,
    input wire logic [frb_pkg::CMD_W-1:0]    i_s_tuser,
    input wire logic                         o_m_tvalid,
    input wire logic                         i_m_tready,
    input wire logic [frb_pkg::SAMPLE_W-1:0] o_m_tdata,
    input wire logic [0:0]                   o_m_tuser,
    input wire logic                         o_m_tlast
);

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a rejected request is always a single result with no sample
    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tlast && (o_m_tdata == '0)))
        else $error("rejected result carries data or lacks last");

    // a stalled result keeps its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("stalled result changed");

    // a flush adds no result, so the request side stays open right after it
    a_flush_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == frb_pkg::CMD_FLUSH)) |=> o_s_tready)
        else $error("flush stalled the request channel");

endmodule

bind framed_ring_buffer_window_read_core frb_checker u_frb_checker (.*);
`default_nettype wire
